[rtl/core/mbet_pkg.sv]
// ----------------------------------------------------------------------------
// mbet_pkg: shared constants for the escape-time engine
// Field widths, fixed-point defaults and checkpoint schedule constants.
// ----------------------------------------------------------------------------
`default_nettype none

package mbet_pkg;

  localparam int IN_W           = 31;
  localparam int IN_FRAC        = 28;
  localparam int COUNT_W        = 16;
  localparam int INT_BITS       = 5;
  localparam int FRAC_BITS_DEF  = 28;
  localparam int MAX_SPAN_DEF   = 1024;
  localparam int FIRST_SPAN     = 32;
  localparam int CYCLE_GUARD    = 8;
  localparam logic [COUNT_W-1:0] MAX_ITER_RESET = 16'd4096;

endpackage

`default_nettype wire

[rtl/core/mbet_mulq.sv]
// ----------------------------------------------------------------------------
// mbet_mulq: registered fixed-point multiplier
// Signed product of two fixed-point values, rounded toward minus infinity to
// FRAC_BITS fraction bits, available in the cycle after the operands.
// ----------------------------------------------------------------------------
`default_nettype none

module mbet_mulq #(
  parameter int FRAC_BITS = mbet_pkg::FRAC_BITS_DEF
) (
  input  wire logic                                      clk,
  input  wire logic signed [FRAC_BITS+mbet_pkg::INT_BITS-1:0] a,
  input  wire logic signed [FRAC_BITS+mbet_pkg::INT_BITS-1:0] b,
  output logic signed      [FRAC_BITS+mbet_pkg::INT_BITS-1:0] p
);

  localparam int W  = FRAC_BITS + mbet_pkg::INT_BITS;
  localparam int M  = FRAC_BITS + 3;
  localparam int QW = 2 * M - FRAC_BITS;

  logic              neg;
  logic signed [W-1:0] abs_a;
  logic signed [W-1:0] abs_b;
  logic [M-1:0]      mag_a;
  logic [M-1:0]      mag_b;
  logic [2*M-1:0]    prod;
  logic [QW-1:0]     quo;
  logic [QW-1:0]     quo_up;
  logic              rem_nz;
  logic [QW-1:0]     res;
  logic signed [W-1:0] p_r;

  assign neg    = a[W-1] ^ b[W-1];
  assign abs_a  = a[W-1] ? -a : a;
  assign abs_b  = b[W-1] ? -b : b;
  assign mag_a  = abs_a[M-1:0];
  assign mag_b  = abs_b[M-1:0];
  assign prod   = mag_a * mag_b;
  assign quo    = prod[2*M-1:FRAC_BITS];
  assign rem_nz = |prod[FRAC_BITS-1:0];
  assign quo_up = quo + QW'(rem_nz);
  assign res    = neg ? -quo_up : quo;

  always_ff @(posedge clk) begin
    p_r <= res[W-1:0];
  end

  assign p = p_r;

endmodule

`default_nettype wire

[rtl/core/mandelbrot_escape_time.sv]
// ----------------------------------------------------------------------------
// mandelbrot_escape_time: Mandelbrot escape-time engine
// Interior shortcut (period-2 bulb, main cardioid), iteration of z*z + c with
// escape test, cycle detection against a doubling-span checkpoint.
//
//   channel  direction  handshake            payload
//   in       input      in_valid / in_stall  in_c_real, in_c_imag (Q3.28, 31 bits)
//   out      output     out_valid/out_stall  out_escape_count
//   cfg      input      cfg_valid/cfg_ready  cfg_max_iterations
//
// A transaction runs the interior test in S_CC to S_CHK, then each iteration
// step in S_RR, S_II and S_SUM on the one shared multiplier (a step ending
// on the linear escape test stops in S_RR); S_DONE loads the output register
// once it is free and returns to S_IDLE, the only state accepting a new point.
// Reset is synchronous and needs no clearing pass; cfg is always ready.
// A finished result waits in the output register; hold while it is full.
// ----------------------------------------------------------------------------
`default_nettype none

module mandelbrot_escape_time #(
  parameter int FRAC_BITS           = mbet_pkg::FRAC_BITS_DEF,
  parameter int MAX_CHECKPOINT_SPAN = mbet_pkg::MAX_SPAN_DEF
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               in_valid,
  output logic                                    in_stall,
  input  wire logic signed [mbet_pkg::IN_W-1:0]   in_c_real,
  input  wire logic signed [mbet_pkg::IN_W-1:0]   in_c_imag,
  output logic                                    out_valid,
  input  wire logic                               out_stall,
  output logic [mbet_pkg::COUNT_W-1:0]            out_escape_count,
  input  wire logic                               cfg_valid,
  output logic                                    cfg_ready,
  input  wire logic [mbet_pkg::COUNT_W-1:0]       cfg_max_iterations
);

  localparam int W   = FRAC_BITS + mbet_pkg::INT_BITS;
  localparam int XW  = W + mbet_pkg::IN_W;
  localparam int CW  = mbet_pkg::COUNT_W;
  localparam int SW  = $clog2(MAX_CHECKPOINT_SPAN + 1);
  localparam int UP  = (FRAC_BITS >= mbet_pkg::IN_FRAC) ? FRAC_BITS - mbet_pkg::IN_FRAC : 0;
  localparam int DN  = (FRAC_BITS >= mbet_pkg::IN_FRAC) ? 0 : mbet_pkg::IN_FRAC - FRAC_BITS;

  localparam logic signed [W-1:0] ONE       = W'(1) << FRAC_BITS;
  localparam logic signed [W-1:0] QUARTER   = W'(1) << (FRAC_BITS - 2);
  localparam logic signed [W-1:0] SIXTEENTH = W'(1) << (FRAC_BITS - 4);
  localparam logic signed [W-1:0] TWO       = W'(2) << FRAC_BITS;
  localparam logic signed [W-1:0] NEG_TWO   = -TWO;
  localparam logic signed [W-1:0] NEG_ONE   = -ONE;
  localparam logic signed [W-1:0] HALF      = QUARTER + QUARTER;
  localparam logic signed [W-1:0] NEG_QTR   = -QUARTER;
  localparam logic signed [W-1:0] BULB_LO   = NEG_ONE - QUARTER;
  localparam logic signed [W-1:0] BULB_HI   = NEG_ONE + QUARTER;
  localparam logic signed [W:0]   FOUR      = (W+1)'(4) << FRAC_BITS;

  typedef enum logic [3:0] {
    S_IDLE, S_CC, S_TT, S_UU, S_Q, S_QQ, S_CHK, S_RR, S_II, S_SUM, S_DONE
  } state_t;

  state_t              state_r;
  logic                out_valid_r;
  logic [CW-1:0]       out_count_r;
  logic [CW-1:0]       max_iter_r;
  logic [CW-1:0]       res_r;
  logic [CW-1:0]       step_r;
  logic [SW-1:0]       since_r;
  logic [SW-1:0]       span_r;
  logic                bulb_r;
  logic signed [W-1:0] cr_r;
  logic signed [W-1:0] ci_r;
  logic signed [W-1:0] cc_r;
  logic signed [W-1:0] q_r;
  logic signed [W-1:0] qu_r;
  logic signed [W-1:0] nr_r;
  logic signed [W-1:0] ni_r;
  logic signed [W-1:0] rr_r;
  logic signed [W-1:0] kr_r;
  logic signed [W-1:0] ki_r;

  logic signed [XW-1:0] ext_real;
  logic signed [XW-1:0] ext_imag;
  logic signed [XW-1:0] scl_real;
  logic signed [XW-1:0] scl_imag;
  logic signed [W-1:0]  mul_a;
  logic signed [W-1:0]  mul_b;
  logic signed [W-1:0]  mul_p;
  logic signed [W-1:0]  t_val;
  logic signed [W-1:0]  u_val;
  logic signed [W-1:0]  q_val;
  logic signed [W-1:0]  qu_val;
  logic signed [W-1:0]  ni_val;
  logic signed [W-1:0]  nr_val;
  logic signed [W:0]    mag_sum;
  logic                 bulb_box;
  logic                 card_box;
  logic                 bulb_hit;
  logic                 card_hit;
  logic                 lin_esc;
  logic                 mag_esc;
  logic                 cyc_hit;
  logic [CW-1:0]        step_inc;
  logic [SW-1:0]        since_inc;
  logic [SW:0]          span_dbl;
  logic [SW-1:0]        span_nxt;

  assign ext_real = XW'(in_c_real);
  assign ext_imag = XW'(in_c_imag);
  assign scl_real = (ext_real <<< UP) >>> DN;
  assign scl_imag = (ext_imag <<< UP) >>> DN;

  assign t_val  = cr_r + ONE;
  assign u_val  = cr_r - QUARTER;
  assign q_val  = mul_p + cc_r;
  assign qu_val = q_val + u_val;

  assign bulb_box = (cr_r >= BULB_LO) && (cr_r <= BULB_HI) &&
                    (ci_r >= NEG_QTR) && (ci_r <= QUARTER);
  assign card_box = (cr_r >= NEG_ONE) && (cr_r <= HALF) &&
                    (ci_r >= NEG_ONE) && (ci_r <= ONE);
  assign bulb_hit = bulb_box && ((mul_p + cc_r) <= SIXTEENTH);
  assign card_hit = card_box && (mul_p <= (cc_r >>> 2));

  assign ni_val  = (mul_p <<< 1) + ci_r;
  assign nr_val  = rr_r - mul_p + cr_r;
  assign lin_esc = (nr_r > TWO) || (nr_r < NEG_TWO) ||
                   (ni_val > TWO) || (ni_val < NEG_TWO);
  assign mag_sum = (W+1)'(rr_r) + (W+1)'(mul_p);
  assign mag_esc = mag_sum > FOUR;

  assign step_inc  = step_r + CW'(1);
  assign since_inc = since_r + SW'(1);
  assign cyc_hit   = (since_inc > SW'(mbet_pkg::CYCLE_GUARD)) &&
                     (nr_r == kr_r) && (ni_r == ki_r);
  assign span_dbl  = {span_r, 1'b0};
  assign span_nxt  = (span_dbl > (SW+1)'(MAX_CHECKPOINT_SPAN)) ?
                     SW'(MAX_CHECKPOINT_SPAN) : span_dbl[SW-1:0];

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_r)
      S_CC: begin
        mul_a = ci_r;
        mul_b = ci_r;
      end
      S_TT: begin
        mul_a = t_val;
        mul_b = t_val;
      end
      S_UU: begin
        mul_a = u_val;
        mul_b = u_val;
      end
      S_QQ: begin
        mul_a = q_r;
        mul_b = qu_r;
      end
      S_RR: begin
        mul_a = nr_r;
        mul_b = nr_r;
      end
      S_II: begin
        mul_a = ni_r;
        mul_b = ni_r;
      end
      S_SUM: begin
        mul_a = nr_r;
        mul_b = ni_r;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  mbet_mulq #(
    .FRAC_BITS (FRAC_BITS)
  ) u_mulq (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .p   (mul_p)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      max_iter_r  <= mbet_pkg::MAX_ITER_RESET;
    end else begin
      if (cfg_valid) begin
        max_iter_r <= cfg_max_iterations;
      end
      if (out_valid_r && !out_stall && (state_r != S_DONE)) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            cr_r    <= scl_real[W-1:0];
            ci_r    <= scl_imag[W-1:0];
            state_r <= S_CC;
          end
        end
        S_CC: begin
          state_r <= S_TT;
        end
        S_TT: begin
          cc_r    <= mul_p;
          state_r <= S_UU;
        end
        S_UU: begin
          bulb_r  <= bulb_hit;
          state_r <= S_Q;
        end
        S_Q: begin
          q_r     <= q_val;
          qu_r    <= qu_val;
          state_r <= S_QQ;
        end
        S_QQ: begin
          state_r <= S_CHK;
        end
        S_CHK: begin
          if (bulb_r || card_hit || (max_iter_r == '0)) begin
            res_r   <= '0;
            state_r <= S_DONE;
          end else begin
            nr_r    <= cr_r;
            kr_r    <= '0;
            ki_r    <= '0;
            step_r  <= '0;
            since_r <= '0;
            span_r  <= SW'(mbet_pkg::FIRST_SPAN);
            state_r <= S_RR;
          end
        end
        S_RR: begin
          if (lin_esc) begin
            res_r   <= step_inc;
            state_r <= S_DONE;
          end else begin
            ni_r    <= ni_val;
            state_r <= S_II;
          end
        end
        S_II: begin
          rr_r    <= mul_p;
          state_r <= S_SUM;
        end
        S_SUM: begin
          if (mag_esc) begin
            res_r   <= step_inc;
            state_r <= S_DONE;
          end else if (cyc_hit || (step_inc == max_iter_r)) begin
            res_r   <= '0;
            state_r <= S_DONE;
          end else begin
            if (since_inc >= span_r) begin
              kr_r    <= nr_r;
              ki_r    <= ni_r;
              since_r <= '0;
              span_r  <= span_nxt;
            end else begin
              since_r <= since_inc;
            end
            step_r  <= step_inc;
            nr_r    <= nr_val;
            state_r <= S_RR;
          end
        end
        S_DONE: begin
          if (!out_valid_r || !out_stall) begin
            out_valid_r <= 1'b1;
            out_count_r <= res_r;
            state_r     <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign in_stall         = (state_r != S_IDLE);
  assign out_valid        = out_valid_r;
  assign out_escape_count = out_count_r;
  assign cfg_ready        = 1'b1;

  a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> (state_r == S_CC))
    else $error("accepted transaction did not start the interior test");

  a_out_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_DONE))
    else $error("result presented without completion");

  a_since_in_span: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_RR) |-> ((since_r < span_r) &&
                           (span_r <= SW'(MAX_CHECKPOINT_SPAN))))
    else $error("checkpoint counter outside its span");

  a_step_below_limit: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == S_CHK) && !bulb_r && !card_hit && (max_iter_r != '0)) |=>
      (step_r == '0))
    else $error("iteration did not start from step zero");

endmodule

`default_nettype wire

[tb/testbench.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench: escape-time engine check
// Feeds points of c to the engine and compares each escape count with a
// fixed-point prediction of z*z + c, the bulb and cardioid shortcut and the
// checkpoint cycle test. Runs directed corner points, then random points
// under several iteration limits, with random idling on both channels.
// ----------------------------------------------------------------------------

module testbench;

  localparam int IN_W         = mbet_pkg::IN_W;
  localparam int IN_FRAC      = mbet_pkg::IN_FRAC;
  localparam int COUNT_W      = mbet_pkg::COUNT_W;
  localparam int FIRST_SPAN   = mbet_pkg::FIRST_SPAN;
  localparam int CYCLE_GUARD  = mbet_pkg::CYCLE_GUARD;
  localparam int MAX_SPAN_DEF = mbet_pkg::MAX_SPAN_DEF;
  localparam int FRAC        = mbet_pkg::FRAC_BITS_DEF;
  localparam int ONE         = 1 << IN_FRAC;
  localparam int QUARTER     = ONE / 4;
  localparam int C_MAX       = (1 << (IN_W - 1)) - 1;
  localparam int C_MIN       = -(1 << (IN_W - 1));
  localparam int STALL_LIMIT = 600000;

  typedef logic signed [63:0] fix_t;

  typedef struct {
    logic signed [IN_W-1:0] re;
    logic signed [IN_W-1:0] im;
  } c_point_t;

  logic                      clk = 1'b0;
  logic                      rst_n = 1'b0;
  logic                      in_valid = 1'b0;
  logic                      in_stall;
  logic signed [IN_W-1:0]    in_c_real = '0;
  logic signed [IN_W-1:0]    in_c_imag = '0;
  logic                      out_valid;
  logic                      out_stall = 1'b0;
  logic [COUNT_W-1:0]        out_escape_count;
  logic                      cfg_valid = 1'b0;
  logic                      cfg_ready;
  logic [COUNT_W-1:0]        cfg_max_iterations = '0;

  c_point_t                  pending_points[$];
  logic [COUNT_W-1:0]        escape_due[$];
  logic [COUNT_W-1:0]        iter_limit = mbet_pkg::MAX_ITER_RESET;
  int                        send_idle_pct = 0;
  int                        recv_idle_pct = 0;
  int                        fail_count = 0;
  int                        quiet_cycles = 0;

  mandelbrot_escape_time dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_c_real          (in_c_real),
    .in_c_imag          (in_c_imag),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_escape_count   (out_escape_count),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_max_iterations (cfg_max_iterations)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // product rounded toward minus infinity
  function automatic fix_t fx_mul(fix_t a, fix_t b);
    logic signed [127:0] p;
    p = $signed({{64{a[63]}}, a}) * $signed({{64{b[63]}}, b});
    return p[FRAC+63:FRAC];
  endfunction

  function automatic fix_t clamp_sum(fix_t a, fix_t b);
    fix_t s;
    s = a + b;
    if (a[63] == b[63] && s[63] != a[63])
      s = a[63] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
    return s;
  endfunction

  function automatic bit in_main_regions(fix_t cr, fix_t ci);
    fix_t one, quarter, sixteenth, t, u, ci2, q;
    one = fix_t'(1) <<< FRAC;
    quarter = fix_t'(1) <<< (FRAC - 2);
    sixteenth = fix_t'(1) <<< (FRAC - 4);
    if (cr >= -one - quarter && cr <= -one + quarter && ci >= -quarter && ci <= quarter) begin
      t = cr + one;
      if (fx_mul(t, t) + fx_mul(ci, ci) <= sixteenth) return 1'b1;
    end
    if (cr >= -one && cr <= 2 * quarter && ci >= -one && ci <= one) begin
      u = cr - quarter;
      ci2 = fx_mul(ci, ci);
      q = fx_mul(u, u) + ci2;
      if (fx_mul(q, q + u) <= (ci2 >>> 2)) return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic logic [COUNT_W-1:0] escape_count_of(logic signed [IN_W-1:0] re,
                                                          logic signed [IN_W-1:0] im,
                                                          logic [COUNT_W-1:0] limit);
    fix_t cr, ci, zr, zi, kr, ki, rr, ii, ri, nr, ni, two, four;
    int unsigned span, since, step;
    cr = fix_t'(re);
    ci = fix_t'(im);
    cr = cr <<< (FRAC - IN_FRAC);
    ci = ci <<< (FRAC - IN_FRAC);
    two = fix_t'(2) <<< FRAC;
    four = fix_t'(4) <<< FRAC;
    zr = '0;
    zi = '0;
    kr = '0;
    ki = '0;
    span = FIRST_SPAN;
    since = 0;
    if (in_main_regions(cr, ci)) return '0;
    for (step = 0; step < limit; step++) begin
      rr = fx_mul(zr, zr);
      ii = fx_mul(zi, zi);
      ri = fx_mul(zr, zi);
      nr = clamp_sum(rr - ii, cr);
      ni = clamp_sum(ri + ri, ci);
      if (nr > two || nr < -two || ni > two || ni < -two) return COUNT_W'(step + 1);
      if (fx_mul(nr, nr) + fx_mul(ni, ni) > four) return COUNT_W'(step + 1);
      zr = nr;
      zi = ni;
      since++;
      if (since > CYCLE_GUARD && zr == kr && zi == ki) return '0;
      if (since >= span) begin
        kr = zr;
        ki = zi;
        since = 0;
        span = span * 2;
        if (span > MAX_SPAN_DEF) span = MAX_SPAN_DEF;
      end
    end
    return '0;
  endfunction

  function automatic c_point_t random_point();
    c_point_t    p;
    int          pick;
    logic [31:0] r;
    int          box_re[6] = '{-5 * QUARTER, -3 * QUARTER, -ONE, 2 * QUARTER, QUARTER, -2 * ONE};
    int          box_im[5] = '{0, QUARTER, -QUARTER, ONE, -ONE};
    pick = $urandom_range(99);
    if (pick < 25) begin
      r = $urandom;
      p.re = r[IN_W-1:0];
      r = $urandom;
      p.im = r[IN_W-1:0];
    end else if (pick < 85) begin
      p.re = IN_W'(int'($urandom_range(3 * ONE)) - 9 * QUARTER);
      p.im = IN_W'(int'($urandom_range(3 * ONE)) - 6 * QUARTER);
    end else begin
      p.re = IN_W'(box_re[$urandom_range(5)] + int'($urandom_range(2048)) - 1024);
      p.im = IN_W'(box_im[$urandom_range(4)] + int'($urandom_range(2048)) - 1024);
    end
    return p;
  endfunction

  task automatic queue_point(input c_point_t p);
    pending_points.insert(pending_points.size(), p);
  endtask

  task automatic add_point(input int re, input int im);
    c_point_t p;
    p.re = re[IN_W-1:0];
    p.im = im[IN_W-1:0];
    queue_point(p);
  endtask

  task automatic write_max_iterations(input logic [COUNT_W-1:0] value);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_max_iterations <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    iter_limit = value;
  endtask

  task automatic wait_all_done();
    @(posedge clk);
    while (pending_points.size() != 0 || in_valid || escape_due.size() != 0) @(posedge clk);
  endtask

  // driver: predict on each accepted transaction, then present the next point
  always @(posedge clk) begin
    c_point_t p;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall)
        escape_due.insert(escape_due.size(),
                          escape_count_of(in_c_real, in_c_imag, iter_limit));
      if (!in_valid || !in_stall) begin
        if (pending_points.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          p = pending_points.pop_front();
          in_valid <= 1'b1;
          in_c_real <= p.re;
          in_c_imag <= p.im;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    logic [COUNT_W-1:0] want;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (escape_due.size() == 0) begin
          $error("escape_count: expected none, actual %0d", out_escape_count);
          fail_count++;
        end else begin
          want = escape_due.pop_front();
          if (out_escape_count !== want) begin
            $error("escape_count: expected %0d, actual %0d", want, out_escape_count);
            fail_count++;
          end
        end
      end
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("mandelbrot_escape_time test failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    c_point_t    p;
    logic [31:0] r;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    send_idle_pct = 28;
    recv_idle_pct = 49;

    add_point(0, 0);
    add_point(C_MAX, C_MAX);
    add_point(C_MIN, C_MIN);
    add_point(C_MAX, C_MIN);
    add_point(C_MIN, C_MAX);
    add_point(-ONE, 0);
    add_point(-5 * QUARTER, 0);
    add_point(-5 * QUARTER - 1, 0);
    add_point(-3 * QUARTER, QUARTER);
    add_point(QUARTER, 0);
    add_point(QUARTER + 1, 0);
    add_point(2 * QUARTER, 0);
    add_point(2 * QUARTER + 1, 0);
    add_point(-ONE, ONE);
    add_point(2 * QUARTER, -ONE);
    add_point(-2 * ONE, 0);
    add_point(-2 * ONE - 1, 0);
    add_point(2 * ONE, 0);
    add_point(0, 2 * ONE);
    add_point(0, ONE);
    add_point(int'(0.3 * ONE), 0);
    add_point(int'(-0.1225611668766536 * ONE), int'(0.7448617666197442 * ONE));
    wait_all_done();

    write_max_iterations(16'd1);
    repeat (25) queue_point(random_point());
    wait_all_done();

    write_max_iterations(16'd0);
    repeat (5) queue_point(random_point());
    wait_all_done();

    send_idle_pct = 49;
    recv_idle_pct = 28;
    write_max_iterations(16'hFFFF);
    repeat (4) begin
      r = $urandom;
      p.re = r[IN_W-1:0];
      r = $urandom;
      p.im = r[IN_W-1:0];
      queue_point(p);
    end
    add_point(-2 * ONE, 0);
    add_point(int'(-0.1225611668766536 * ONE), int'(0.7448617666197442 * ONE));
    wait_all_done();

    for (int phase = 0; phase < 4; phase++) begin
      if (phase == 2) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      write_max_iterations(16'($urandom_range(400, 16)));
      repeat (22) queue_point(random_point());
      wait_all_done();
    end

    repeat (20) @(posedge clk);
    if (fail_count == 0) begin
      $display("mandelbrot_escape_time test passed");
    end else begin
      $display("mandelbrot_escape_time test failed");
    end
    $finish;
  end

endmodule

[filelist.f]
rtl/core/mbet_pkg.sv
rtl/core/mbet_mulq.sv
rtl/core/mandelbrot_escape_time.sv
tb/testbench.sv
